@@ hw/rtl/swm_pkg.sv @@
// Package for the sliding-window median unit.
// Shared widths, defaults and the sensor word decode; no dependencies.
`default_nettype none

package swm_pkg;

	localparam int RAW_W          = 16;
	localparam int TEMP_W         = 8;
	localparam int HELD_W         = 3;
	localparam int WINDOW_LEN_DEF = 6;

	localparam logic [RAW_W-1:0] TEMP_MASK = 16'h0FFF;
	localparam int               FRAC_W    = 4;

	typedef logic [TEMP_W-1:0] temp_t;
	typedef logic [RAW_W-1:0]  raw_t;
	typedef logic [HELD_W-1:0] held_t;

	// Drop flag and sign bits, truncate the fraction: whole degrees.
	function automatic temp_t raw_to_degrees(input raw_t raw);
		raw_t masked;
		masked = raw & TEMP_MASK;
		return masked[FRAC_W +: TEMP_W];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/swm_if.sv @@
// Valid/ready channel interfaces for the sliding-window median unit.
// Depends on swm_pkg for payload types.
`default_nettype none

interface swm_sample_if
	import swm_pkg::*;
	();
	logic  valid;
	logic  ready;
	raw_t  raw_reading;
	logic  read_ok;

	modport source (output valid, output raw_reading, output read_ok, input ready);
	modport sink   (input valid, input raw_reading, input read_ok, output ready);
endinterface

interface swm_result_if
	import swm_pkg::*;
	();
	logic  valid;
	logic  ready;
	temp_t median_temp;
	held_t samples_held;

	modport source (output valid, output median_temp, output samples_held, input ready);
	modport sink   (input valid, input median_temp, input samples_held, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sensor_word_window_median_unit.sv @@
// Sliding-window median of sensor temperature words, top level.
// Depends on swm_pkg, swm_if, swm_window and swm_median.
//
// Usage:
//   sample channel: one raw 16-bit sensor word plus read_ok per item.
//   An item with read_ok low is taken and dropped: no state change, no result.
//   An item with read_ok high puts bits 11..4 into the window; once the
//   window holds WINDOW_LEN readings the oldest one falls out.
//   result channel: median of the held readings (mean of the two middle
//   values, rounded half up, for an even count) and the count, low 3 bits.
// Path: the window register updates at accept, the median is formed from it
//   combinationally and lands in the result register once that register is
//   free.
// Throughput: one item per cycle while the result channel does not stall; the
//   rank-and-select median logic between the window and result registers is combinational.
// Reset: window cleared to zero, count zero, no result pending.
// Stall: a held result blocks the window stage only when that stage also
//   holds an item; sample.ready then drops until result.ready returns.
`default_nettype none

module sensor_word_window_median_unit
	import swm_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	swm_sample_if.sink    sample,
	swm_result_if.source  result
);

	localparam int CNT_W = $clog2(WINDOW_LEN + 1);

	logic [WINDOW_LEN-1:0][TEMP_W-1:0] window;
	logic [CNT_W-1:0]                  count;
	logic [CNT_W+HELD_W-1:0]           count_ext;
	temp_t                             median;
	logic                              valid_s1;
	logic                              out_valid_q;
	temp_t                             median_q;
	held_t                             held_q;
	logic                              out_free;
	logic                              advance;
	logic                              push;

	assign out_free = !out_valid_q || result.ready;
	assign advance  = !valid_s1 || out_free;
	assign push     = sample.valid && advance && sample.read_ok;

	assign sample.ready = advance;

	swm_window #(
		.WINDOW_LEN (WINDOW_LEN),
		.CNT_W      (CNT_W)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.reading (raw_to_degrees(sample.raw_reading)),
		.window  (window),
		.count   (count)
	);

	swm_median #(
		.WINDOW_LEN (WINDOW_LEN),
		.CNT_W      (CNT_W)
	) u_median (
		.window (window),
		.count  (count),
		.median (median)
	);

	assign count_ext = {{HELD_W{1'b0}}, count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			median_q <= median;
			held_q   <= count_ext[HELD_W-1:0];
		end
	end

	assign result.valid        = out_valid_q;
	assign result.median_temp  = median_q;
	assign result.samples_held = held_q;

endmodule

`default_nettype wire

@@ hw/rtl/swm_window.sv @@
// Window storage: the last WINDOW_LEN readings, oldest first, and the fill count.
// Depends on swm_pkg.
`default_nettype none

module swm_window
	import swm_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int CNT_W      = $clog2(WINDOW_LEN + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire temp_t                        reading,
	output logic      [WINDOW_LEN-1:0][TEMP_W-1:0] window,
	output logic      [CNT_W-1:0]             count
);

	logic [WINDOW_LEN-1:0][TEMP_W-1:0] win_q;
	logic [CNT_W-1:0]                  count_q;
	logic [WINDOW_LEN:0][TEMP_W-1:0]   ext;
	logic                              full;

	assign ext  = {reading, win_q};
	assign full = (count_q == CNT_W'(WINDOW_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			count_q <= '0;
		end else if (push) begin
			if (full) begin
				win_q <= ext[WINDOW_LEN:1];
			end else begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					if (count_q == CNT_W'(i)) begin
						win_q[i] <= reading;
					end
				end
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	assign window = win_q;
	assign count  = count_q;

endmodule

`default_nettype wire

@@ hw/rtl/swm_median.sv @@
// Median of the valid window entries by pairwise rank and one-hot select.
// Depends on swm_pkg.
`default_nettype none

module swm_median
	import swm_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int CNT_W      = $clog2(WINDOW_LEN + 1)
) (
	input  wire logic [WINDOW_LEN-1:0][TEMP_W-1:0] window,
	input  wire logic [CNT_W-1:0]                  count,
	output temp_t                                  median
);

	logic [WINDOW_LEN-1:0][CNT_W-1:0] rank;
	logic [WINDOW_LEN-1:0]            valid;
	logic [CNT_W-1:0]                 lo_pos;
	logic [CNT_W-1:0]                 hi_pos;
	temp_t                            lo_val;
	temp_t                            hi_val;
	logic [TEMP_W:0]                  sum;

	always_comb begin
		for (int i = 0; i < WINDOW_LEN; i++) begin
			valid[i] = (CNT_W'(i) < count);
		end
		for (int i = 0; i < WINDOW_LEN; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW_LEN; j++) begin
				if (valid[j] && ((window[j] < window[i]) ||
						((window[j] == window[i]) && (j < i)))) begin
					rank[i] = rank[i] + CNT_W'(1);
				end
			end
		end
		lo_pos = (count - CNT_W'(1)) >> 1;
		hi_pos = count >> 1;
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			if (valid[i] && (rank[i] == lo_pos)) begin
				lo_val = lo_val | window[i];
			end
			if (valid[i] && (rank[i] == hi_pos)) begin
				hi_val = hi_val | window[i];
			end
		end
		sum    = {1'b0, lo_val} + {1'b0, hi_val} + (TEMP_W+1)'(1);
		median = sum[TEMP_W:1];
	end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for sensor_word_window_median_unit.
// Drives raw sensor words over the sample channel and checks every median and held count
// against a local window model or the directed table; depends on swm_pkg, swm_if and the unit's RTL.
`default_nettype none

module tb;
	import swm_pkg::*;

	localparam int WIN        = WINDOW_LEN_DEF;
	localparam int N_RANDOM   = 450;
	localparam int PAUSE_AT   = 200;

	typedef struct packed {
		raw_t  raw;
		logic  ok;
		logic  typed;
		temp_t med;
		held_t held;
	} dir_row_t;

	typedef struct packed {
		temp_t med;
		held_t held;
	} median_exp_t;

	localparam int N_DIR = 18;
	localparam dir_row_t DIRECTED [N_DIR] = '{
		'{16'h0000, 1'b0, 1'b0, 8'd0,   3'd0},
		'{16'hFFFF, 1'b1, 1'b1, 8'd255, 3'd1},
		'{16'h0000, 1'b1, 1'b1, 8'd128, 3'd2},
		'{16'hF00F, 1'b1, 1'b1, 8'd0,   3'd3},
		'{16'hFFFF, 1'b0, 1'b0, 8'd0,   3'd0},
		'{16'h0FF0, 1'b1, 1'b1, 8'd128, 3'd4},
		'{16'h0010, 1'b1, 1'b1, 8'd1,   3'd5},
		'{16'h0800, 1'b1, 1'b1, 8'd65,  3'd6},
		'{16'h07F0, 1'b1, 1'b0, 8'd0,   3'd0},
		'{16'h1234, 1'b1, 1'b0, 8'd0,   3'd0},
		'{16'h5678, 1'b1, 1'b0, 8'd0,   3'd0},
		'{16'hAAAA, 1'b0, 1'b0, 8'd0,   3'd0},
		'{16'hABCD, 1'b1, 1'b0, 8'd0,   3'd0},
		'{16'h8000, 1'b1, 1'b0, 8'd0,   3'd0},
		'{16'h7FFF, 1'b1, 1'b0, 8'd0,   3'd0},
		'{16'h0001, 1'b1, 1'b0, 8'd0,   3'd0},
		'{16'h5555, 1'b1, 1'b0, 8'd0,   3'd0},
		'{16'h0000, 1'b0, 1'b0, 8'd0,   3'd0}
	};

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   n_items;
	int   n_bus_err;
	int   n_checked;
	int   n_fail;

	temp_t       window_hold [WIN];
	int          fill_level;
	median_exp_t median_q [$];

	swm_sample_if sample ();
	swm_result_if result ();

	sensor_word_window_median_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic temp_t window_median();
		temp_t      srt [WIN];
		temp_t      v;
		logic [8:0] sum;
		int         i;
		int         j;
		for (i = 0; i < fill_level; i++) begin
			v = window_hold[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		if (fill_level % 2 == 1)
			return srt[fill_level/2];
		sum = {1'b0, srt[fill_level/2-1]} + {1'b0, srt[fill_level/2]} + 9'd1;
		return sum[8:1];
	endfunction

	function automatic bit window_update(input raw_t raw, input logic ok,
			output temp_t med, output held_t held);
		int i;
		med = '0;
		held = '0;
		if (!ok)
			return 1'b0;
		if (fill_level < WIN) begin
			window_hold[fill_level] = raw[11:4];
			fill_level++;
		end else begin
			for (i = 1; i < WIN; i++)
				window_hold[i-1] = window_hold[i];
			window_hold[WIN-1] = raw[11:4];
		end
		med = window_median();
		held = held_t'(fill_level);
		return 1'b1;
	endfunction

	task automatic send_sample(input raw_t raw, input logic ok, input bit typed,
			input temp_t tmed, input held_t theld);
		int          gap;
		temp_t       med;
		held_t       held;
		median_exp_t e;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid       <= 1'b1;
		sample.raw_reading <= raw;
		sample.read_ok     <= ok;
		do @(posedge clk); while (!sample.ready);
		n_items++;
		if (!ok)
			n_bus_err++;
		if (window_update(raw, ok, med, held)) begin
			e.med  = typed ? tmed : med;
			e.held = typed ? theld : held;
			median_q = {median_q, e};
		end
	endtask

	function automatic raw_t pick_raw();
		raw_t r;
		r = raw_t'($urandom);
		case ($urandom_range(0, 9))
			0: r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1: r = {r[15:12], 4'hF, 4'hF, r[3:0]};
			2: r = {r[15:12], 8'h00, r[3:0]};
			3: if (fill_level > 0) r[11:4] = window_hold[$urandom_range(0, fill_level-1)];
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		raw_t r;
		int   k;
		arst_n             = 1'b0;
		sample.valid       = 1'b0;
		sample.raw_reading = '0;
		sample.read_ok     = 1'b0;
		idle_on            = 1'b1;
		fill_level         = 0;
		n_items            = 0;
		n_bus_err          = 0;
		n_checked          = 0;
		n_fail             = 0;
		for (k = 0; k < WIN; k++)
			window_hold[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < N_DIR; k++)
			send_sample(DIRECTED[k].raw, DIRECTED[k].ok, DIRECTED[k].typed,
				DIRECTED[k].med, DIRECTED[k].held);
		for (k = 0; k < N_RANDOM; k++) begin
			if (k % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (k == PAUSE_AT) begin
				sample.valid <= 1'b0;
				@(posedge clk);
				while (median_q.size() != 0) @(posedge clk);
			end
			r = pick_raw();
			send_sample(r, $urandom_range(0, 6) != 0, 1'b0, '0, '0);
		end
		sample.valid <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d sample items, %0d of them bus errors; checked %0d medians.",
			n_items, n_bus_err, n_checked);
		if (n_fail == 0 && median_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		int gap;
		result.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = idle_on ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	always @(posedge clk) begin
		median_exp_t e;
		if (arst_n && result.valid && result.ready) begin
			if (median_q.size() == 0) begin
				$display("%0t unexpected result: median_temp %0d samples_held %0d",
					$time, result.median_temp, result.samples_held);
				n_fail++;
			end else begin
				e = median_q.pop_front();
				n_checked++;
				if (result.median_temp !== e.med) begin
					$display("%0t median_temp expected %0d actual %0d",
						$time, e.med, result.median_temp);
					n_fail++;
				end
				if (result.samples_held !== e.held) begin
					$display("%0t samples_held expected %0d actual %0d",
						$time, e.held, result.samples_held);
					n_fail++;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_window.sv
hw/rtl/swm_median.sv
hw/rtl/sensor_word_window_median_unit.sv
tb/sv/tb.sv
